[hw/rtl/convolution_3x3_rgb_replicate_assert.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the 3x3 RGB convolution block
// Immediate-implication and next-cycle forms, sampled on the rising clock edge
// and disabled while the asynchronous reset is asserted.
// -----------------------------------------------------------------------------
`ifndef CONVOLUTION_3X3_RGB_REPLICATE_ASSERT_SVH
`define CONVOLUTION_3X3_RGB_REPLICATE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CONV3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("conv3: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define CONV3_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("conv3: next-cycle check failed");

`endif

[hw/rtl/conv3_pkg.sv]
// -----------------------------------------------------------------------------
// conv3_pkg
// Types, register codes and constants shared by the 3x3 RGB convolution block.
// -----------------------------------------------------------------------------
package conv3_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int COEF_BITS_DEF = 16;
	// Column fields are sized for the widest supported row.
	localparam int COL_W = 13;
	localparam int ROW_W = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MIDDLE = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_IMAGE_HEIGHT  = 3'd4
	} cfg_reg_t;

	localparam logic [47:0] KERNEL_TOP_RST = 48'h0;
	localparam logic [47:0] KERNEL_MIDDLE_RST = 48'h0000_0001_0000;
	localparam logic [47:0] KERNEL_BOTTOM_RST = 48'h0;
	localparam logic [10:0] WIDTH_RST = 11'd1024;
	localparam logic [15:0] HEIGHT_RST = 16'd768;

	typedef struct packed {
		logic       operation;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_t;

	typedef struct packed {
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [9:0]  out_column;
		logic [15:0] out_row;
		logic        frame_done;
		logic        run_last;
	} out_t;

	typedef logic [23:0] pix_t;
	// Index 0 is the top row, 2 the bottom row.
	typedef logic [2:0][23:0] col_t;
	// Index 0 is the left column, 2 the right column.
	typedef logic [2:0][2:0][23:0] win_t;

	typedef struct packed {
		logic [47:0] top;
		logic [47:0] middle;
		logic [47:0] bottom;
	} kernel_t;

	typedef enum logic [1:0] {
		CMD_PIXEL   = 2'd0,
		CMD_DRAIN   = 2'd1,
		CMD_PRELOAD = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] addr;
		logic [ROW_W-1:0] row;
		logic             emit1;
		logic             emit2;
		logic             last;
		logic             top_new;
		pix_t             pix;
	} cmd_t;

	typedef struct packed {
		win_t        win;
		logic [9:0]  column;
		logic [15:0] row;
		logic        done;
		logic        last;
	} job_t;

endpackage

[hw/rtl/conv3_ram.sv]
// -----------------------------------------------------------------------------
// conv3_ram
// Generic one-write, one-read memory with a registered read port.
// -----------------------------------------------------------------------------
module conv3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/conv3_front.sv]
// -----------------------------------------------------------------------------
// conv3_front
// Configuration registers, raster position counters and item classification.
// Turns each accepted item into a command for the back end.
// -----------------------------------------------------------------------------
module conv3_front #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [conv3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  conv3_pkg::in_t                      src_data,
	output conv3_pkg::kernel_t                  kernel,
	output logic                                push,
	output conv3_pkg::cmd_t                     push_data,
	input  logic                                full
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WEW = $clog2(MAX_WIDTH + 1);

	conv3_pkg::kernel_t kernel_q;
	logic [10:0]    width_q;
	logic [15:0]    height_q;
	logic [CW-1:0]  col_q;
	logic [CW-1:0]  drain_q;
	logic [15:0]    row_q;
	logic           draining_q;
	logic           preloaded_q;

	logic [WEW-1:0] w_eff;
	logic [CW-1:0]  wm1;
	logic [15:0]    hm1;
	logic           row_end;
	logic           frame_end;
	logic           d_last;
	logic           is_drain;
	logic           need_preload;
	logic           accept;
	logic           preload_push;
	logic           pix_push;
	logic           drain_push;

	assign cfg_ready = 1'b1;
	assign kernel = kernel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q.top <= conv3_pkg::KERNEL_TOP_RST;
			kernel_q.middle <= conv3_pkg::KERNEL_MIDDLE_RST;
			kernel_q.bottom <= conv3_pkg::KERNEL_BOTTOM_RST;
			width_q <= conv3_pkg::WIDTH_RST;
			height_q <= conv3_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				conv3_pkg::REG_KERNEL_TOP: kernel_q.top <= cfg_data;
				conv3_pkg::REG_KERNEL_MIDDLE: kernel_q.middle <= cfg_data;
				conv3_pkg::REG_KERNEL_BOTTOM: kernel_q.bottom <= cfg_data;
				conv3_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data[10:0];
				conv3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// A width of zero acts as one; widths above the line store act as its size.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WEW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = WEW'(width_q);
		end
	end

	assign wm1 = CW'(w_eff - WEW'(1));
	assign hm1 = (height_q == '0) ? 16'd0 : height_q - 16'd1;
	assign row_end = col_q >= wm1;
	assign frame_end = row_q >= hm1;
	assign d_last = drain_q >= wm1;

	assign is_drain = src_data.operation == conv3_pkg::OP_DRAIN;
	// The first drain step needs column 0 prefetched ahead of its own read.
	assign need_preload = src_valid && is_drain && draining_q && (drain_q == '0) && !preloaded_q;
	assign src_stall = full || need_preload;
	assign accept = src_valid && !src_stall;
	assign preload_push = need_preload && !full;
	assign pix_push = accept && !is_drain && !draining_q;
	assign drain_push = accept && is_drain && draining_q;
	assign push = preload_push || pix_push || drain_push;

	always_comb begin
		push_data = '0;
		push_data.pix = {src_data.red_in, src_data.green_in, src_data.blue_in};
		if (preload_push) begin
			push_data.kind = conv3_pkg::CMD_PRELOAD;
			push_data.top_new = row_q == '0;
		end else if (drain_push) begin
			push_data.kind = conv3_pkg::CMD_DRAIN;
			push_data.col = conv3_pkg::COL_W'(drain_q);
			push_data.addr = d_last ? conv3_pkg::COL_W'(drain_q)
				: conv3_pkg::COL_W'(drain_q + CW'(1));
			push_data.row = row_q;
			push_data.last = d_last;
			push_data.top_new = row_q == '0;
		end else begin
			push_data.kind = conv3_pkg::CMD_PIXEL;
			push_data.col = conv3_pkg::COL_W'(col_q);
			push_data.addr = conv3_pkg::COL_W'(col_q);
			push_data.row = row_q - 16'd1;
			push_data.emit1 = (row_q != '0) && (col_q != '0);
			push_data.emit2 = (row_q != '0) && row_end;
			push_data.top_new = row_q <= 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			drain_q <= '0;
			draining_q <= 1'b0;
			preloaded_q <= 1'b0;
		end else begin
			if (preload_push) begin
				preloaded_q <= 1'b1;
			end
			if (pix_push) begin
				if (row_end) begin
					col_q <= '0;
					if (frame_end) begin
						draining_q <= 1'b1;
						drain_q <= '0;
					end else begin
						row_q <= row_q + 16'd1;
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (drain_push) begin
				preloaded_q <= 1'b0;
				if (d_last) begin
					draining_q <= 1'b0;
					drain_q <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					drain_q <= drain_q + CW'(1);
				end
			end
		end
	end

endmodule

[hw/rtl/conv3_fifo.sv]
// -----------------------------------------------------------------------------
// conv3_fifo
// Short command queue between the front end and the back end.
// -----------------------------------------------------------------------------
module conv3_fifo #(
	parameter int DEPTH = conv3_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  conv3_pkg::cmd_t push_data,
	input  logic            pop,
	output conv3_pkg::cmd_t pop_data,
	output logic            full,
	output logic            empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	conv3_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full = count_q == CNTW'(DEPTH);
	assign empty = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

[hw/rtl/conv3_back.sv]
// -----------------------------------------------------------------------------
// conv3_back
// Executes queued commands: reads and updates the two line stores, keeps the
// sliding window columns and hands 3x3 windows to the convolution pipeline.
// -----------------------------------------------------------------------------
module conv3_back #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	output logic            pop,
	input  conv3_pkg::cmd_t cmd,
	output logic            job_valid,
	input  logic            job_ready,
	output conv3_pkg::job_t job
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic            v_s1;
	conv3_pkg::cmd_t cmd_s1;
	logic            hit_s1;
	conv3_pkg::pix_t fwd_old_s1;
	logic            phase_q;
	conv3_pkg::col_t win_a_q;
	conv3_pkg::col_t win_b_q;
	conv3_pkg::col_t drain_l_q;
	conv3_pkg::col_t drain_c_q;

	conv3_pkg::pix_t older_rd;
	conv3_pkg::pix_t newer_rd;
	conv3_pkg::pix_t o_eff;
	conv3_pkg::pix_t n_eff;
	conv3_pkg::pix_t top_pix;
	conv3_pkg::col_t cur_pix;
	conv3_pkg::col_t cur_drn;
	conv3_pkg::pix_t fwd_new_s1;
	logic [conv3_pkg::COL_W-1:0] col_m1;
	logic            is_pixel;
	logic            has_job;
	logic            last_job;
	logic            retire;
	logic            wr_en;

	conv3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd_s1.addr[AW-1:0]),
		.wdata (n_eff),
		.re    (pop),
		.raddr (cmd.addr[AW-1:0]),
		.rdata (older_rd)
	);

	conv3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cmd_s1.addr[AW-1:0]),
		.wdata (cmd_s1.pix),
		.re    (pop),
		.raddr (cmd.addr[AW-1:0]),
		.rdata (newer_rd)
	);

	// A read issued in the same cycle as a write to that column returns the
	// old contents, so the written values are forwarded instead.
	assign o_eff = hit_s1 ? fwd_old_s1 : older_rd;
	assign n_eff = hit_s1 ? fwd_new_s1 : newer_rd;

	assign is_pixel = cmd_s1.kind == conv3_pkg::CMD_PIXEL;
	assign col_m1 = cmd_s1.col - conv3_pkg::COL_W'(1);

	always_comb begin
		top_pix = cmd_s1.top_new ? n_eff : o_eff;
		cur_pix[0] = top_pix;
		cur_pix[1] = n_eff;
		cur_pix[2] = cmd_s1.pix;
		cur_drn[0] = top_pix;
		cur_drn[1] = n_eff;
		cur_drn[2] = n_eff;
	end

	always_comb begin
		has_job = 1'b0;
		last_job = 1'b1;
		job = '0;
		case (cmd_s1.kind)
			conv3_pkg::CMD_PIXEL: begin
				has_job = cmd_s1.emit1 || cmd_s1.emit2;
				last_job = !(cmd_s1.emit1 && cmd_s1.emit2) || phase_q;
				job.row = cmd_s1.row;
				if (cmd_s1.emit1 && !phase_q) begin
					job.win[0] = (cmd_s1.col == conv3_pkg::COL_W'(1)) ? win_b_q : win_a_q;
					job.win[1] = win_b_q;
					job.win[2] = cur_pix;
					job.column = col_m1[9:0];
					job.last = !cmd_s1.emit2;
				end else begin
					job.win[0] = (cmd_s1.col == '0) ? cur_pix : win_b_q;
					job.win[1] = cur_pix;
					job.win[2] = cur_pix;
					job.column = cmd_s1.col[9:0];
					job.last = 1'b1;
				end
			end
			conv3_pkg::CMD_DRAIN: begin
				has_job = 1'b1;
				job.win[0] = drain_l_q;
				job.win[1] = drain_c_q;
				job.win[2] = cur_drn;
				job.column = cmd_s1.col[9:0];
				job.row = cmd_s1.row;
				job.done = cmd_s1.last;
				job.last = 1'b1;
			end
			default: ;
		endcase
	end

	assign job_valid = v_s1 && has_job;
	assign retire = v_s1 && (!has_job || (job_ready && last_job));
	assign pop = !empty && (!v_s1 || retire);
	assign wr_en = retire && is_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (retire) begin
				v_s1 <= 1'b0;
			end
			if (retire) begin
				phase_q <= 1'b0;
			end else if (job_valid && job_ready) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= cmd;
			hit_s1 <= wr_en && (cmd_s1.addr[AW-1:0] == cmd.addr[AW-1:0]);
			fwd_old_s1 <= n_eff;
			fwd_new_s1 <= cmd_s1.pix;
		end
		if (retire) begin
			case (cmd_s1.kind)
				conv3_pkg::CMD_PIXEL: begin
					win_a_q <= win_b_q;
					win_b_q <= cur_pix;
				end
				conv3_pkg::CMD_DRAIN: begin
					drain_l_q <= drain_c_q;
					drain_c_q <= cur_drn;
				end
				conv3_pkg::CMD_PRELOAD: begin
					drain_l_q <= cur_drn;
					drain_c_q <= cur_drn;
				end
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/conv3_mac.sv]
// -----------------------------------------------------------------------------
// conv3_mac
// Three-stage multiply-accumulate pipeline: 27 products, row sums, then the
// final sum with clamping into the output register.
// -----------------------------------------------------------------------------
module conv3_mac #(
	parameter int COEF_BITS = conv3_pkg::COEF_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  conv3_pkg::kernel_t kernel,
	input  logic               job_valid,
	output logic               job_ready,
	input  conv3_pkg::job_t    job,
	output logic               dst_valid,
	input  logic               dst_stall,
	output conv3_pkg::out_t    dst_data
);

	localparam int PW = COEF_BITS + 9;
	localparam int RW = PW + 2;
	localparam int SW = PW + 4;

	logic [2:0][47:0] krows;
	logic signed [COEF_BITS-1:0] coef [3][3];
	logic signed [PW-1:0] prod_d [3][3][3];
	logic signed [PW-1:0] prod_m1 [3][3][3];
	logic signed [RW-1:0] rsum_m2 [3][3];
	logic signed [SW-1:0] tot [3];
	conv3_pkg::out_t meta_d;
	conv3_pkg::out_t dst_d;
	conv3_pkg::out_t meta_m1;
	conv3_pkg::out_t meta_m2;
	conv3_pkg::out_t dst_q;
	logic v_m1;
	logic v_m2;
	logic dst_valid_q;
	logic ready_out;
	logic ready_m2;

	function automatic logic [7:0] clamp8(input logic signed [SW-1:0] s);
		logic [7:0] r;
		if (s[SW-1]) begin
			r = 8'd0;
		end else if (s > $signed(SW'(255))) begin
			r = 8'd255;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

	assign krows[0] = kernel.top;
	assign krows[1] = kernel.middle;
	assign krows[2] = kernel.bottom;

	// Each 16-bit slot holds its coefficient in the low COEF_BITS bits.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef[r][c] = krows[r][32 - 16 * c +: COEF_BITS];
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_d[ch][r][c] = PW'($signed({1'b0, job.win[c][r][23 - 8 * ch -: 8]}))
						* PW'(coef[r][c]);
				end
			end
		end
	end

	assign ready_out = !dst_valid_q || !dst_stall;
	assign ready_m2 = !v_m2 || ready_out;
	assign job_ready = !v_m1 || ready_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			dst_valid_q <= 1'b0;
		end else begin
			if (job_ready) begin
				v_m1 <= job_valid;
			end
			if (ready_m2) begin
				v_m2 <= v_m1;
			end
			if (ready_out) begin
				dst_valid_q <= v_m2;
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot[ch] = SW'(rsum_m2[ch][0]) + SW'(rsum_m2[ch][1]) + SW'(rsum_m2[ch][2]);
		end
	end

	always_comb begin
		meta_d = '0;
		meta_d.out_column = job.column;
		meta_d.out_row = job.row;
		meta_d.frame_done = job.done;
		meta_d.run_last = job.last;
		dst_d = meta_m2;
		dst_d.red_out = clamp8(tot[0]);
		dst_d.green_out = clamp8(tot[1]);
		dst_d.blue_out = clamp8(tot[2]);
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			prod_m1 <= prod_d;
			meta_m1 <= meta_d;
		end
		if (ready_m2 && v_m1) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int r = 0; r < 3; r++) begin
					rsum_m2[ch][r] <= RW'(prod_m1[ch][r][0]) + RW'(prod_m1[ch][r][1])
						+ RW'(prod_m1[ch][r][2]);
				end
			end
			meta_m2 <= meta_m1;
		end
		if (ready_out && v_m2) begin
			dst_q <= dst_d;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data = dst_q;

endmodule

[hw/rtl/convolution_3x3_rgb_replicate.sv]
// -----------------------------------------------------------------------------
// convolution_3x3_rgb_replicate
// 3x3 integer convolution of an RGB888 raster stream with replicated borders.
//
//   Channel  Handshake          Carries
//   cfg      cfg_valid/ready    register index and 48-bit write data
//   src      src_valid/stall    pixel or drain step (in_t)
//   dst      dst_valid/stall    filtered pixel with position (out_t)
//
// While nothing stalls, one input item is taken per clock; a row-ending pixel
// can yield two results, which the convolution pipeline takes one per clock,
// the four-entry command queue absorbing the extra one. The first drain step
// of a frame is held back while column 0 is prefetched. Items pass the queue,
// the back-end command register and the product, row-sum and output stages.
// Reset restores the configuration defaults and clears counters and valid
// flags; the line stores keep old contents and are only read where written.
// -----------------------------------------------------------------------------
`include "convolution_3x3_rgb_replicate_assert.svh"

module convolution_3x3_rgb_replicate #(
	parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF,
	parameter int COEF_BITS = conv3_pkg::COEF_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [conv3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [conv3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             src_valid,
	output logic                             src_stall,
	input  conv3_pkg::in_t                   src_data,
	output logic                             dst_valid,
	input  logic                             dst_stall,
	output conv3_pkg::out_t                  dst_data
);

	conv3_pkg::kernel_t kernel;
	conv3_pkg::cmd_t    push_data;
	conv3_pkg::cmd_t    pop_data;
	conv3_pkg::job_t    job;
	logic push;
	logic pop;
	logic full;
	logic empty;
	logic job_valid;
	logic job_ready;

	conv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.kernel    (kernel),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	conv3_fifo #(.DEPTH(conv3_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	conv3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.cmd       (pop_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	conv3_mac #(.COEF_BITS(COEF_BITS)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.kernel    (kernel),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	`CONV3_ASSERT_IMP(a_queue_no_overflow, clk, arst_n, push, !full)
	`CONV3_ASSERT_IMP(a_queue_no_underflow, clk, arst_n, pop, !empty)
	`CONV3_ASSERT_NEXT(a_queue_push_lands, clk, arst_n, push && !pop, !empty)
	`CONV3_ASSERT_IMP(a_done_is_last, clk, arst_n, dst_valid && dst_data.frame_done, dst_data.run_last)

endmodule
